>>> hw/rtl/tktl_pkg.sv
`default_nettype none
package tktl_pkg;

   // key and byte geometry
   localparam int NUM_KEYS = 4;
   localparam int CTRL_W   = 8;
   localparam int KEYS_W   = 8;
   localparam int LOCK_W   = 8;
   localparam int DRIVE_W  = 4;

   // key sense positions inside the scan bitmap, in handling order
   localparam logic [2:0] KEY_POS [0:3] = '{3'd0, 3'd3, 3'd4, 3'd7};

   // lockout reload value after reset
   localparam logic [LOCK_W-1:0] LOCKOUT_RESET = 8'd200;

   // request operation codes
   localparam logic OP_SCAN = 1'b0;
   localparam logic OP_RX   = 1'b1;

   // csr map
   localparam int              CSR_ADDR_W   = 3;
   localparam int              CSR_DATA_W   = 32;
   localparam logic            REG_LOCKOUT  = 1'b0;

   // job queue between front and back
   localparam int JOB_DEPTH = 2;
   localparam int JOB_PTR_W = $clog2(JOB_DEPTH);
   localparam int JOB_CNT_W = $clog2(JOB_DEPTH + 1);

   typedef struct packed {
      logic              op;
      logic [KEYS_W-1:0] key_bits;
      logic [CTRL_W-1:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic [CTRL_W-1:0]  control_byte;
      logic [DRIVE_W-1:0] led_drive;
      logic [DRIVE_W-1:0] gate_drive;
      logic               send_valid;
      logic [CTRL_W-1:0]  send_byte;
      logic               last;
   } rsp_type;

   // classified request: toggle mask for scans, new byte for receives
   typedef struct packed {
      logic                op;
      logic [NUM_KEYS-1:0] mask;
      logic [CTRL_W-1:0]   rx_byte;
   } job_type;

   // queue status seen by the request handshake and the back
   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

endpackage
`default_nettype wire

>>> hw/rtl/touch_key_toggle_lockout_core.sv
`default_nettype none
// Touch key toggle controller with per-key lockout. A request is accepted while the job queue
// is not full; the front reads keys 0, 3, 4 and 7 of the bitmap, updates the four lockout
// counters and queues a toggle mask. The back turns each queued request into its results
// at one result per cycle unless an unpopped result holds the output: a scan gives one
// result per toggling key (one quiet result if none toggles), a received byte gives one
// echo result. A request gives one to four results; the first result passes through the
// queue slot, the back's job register and its output register. The two-entry job queue
// lets scans keep arriving while results are drained. lockout_scans sits at csr byte
// address 0 and resets to 200; write it only while no request is in flight.
module touch_key_toggle_lockout_core
   import tktl_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_push,
   output logic                       req_full,
   input  wire req_type               req_data,
   output logic                       rsp_empty,
   input  wire logic                  rsp_pop,
   output rsp_type                    rsp_data,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0]      csr_prdata,
   output logic                       csr_pready
);

   logic [LOCK_W-1:0] lockout_ff, lockout_in;
   logic              accept;
   logic              q_pop;
   job_type           job, q_data;
   q_stat_type        q_stat;

   // csr access
   always_comb begin
      csr_pready = 1'b1;
      lockout_in = lockout_ff;
      if (csr_psel && csr_penable && csr_pwrite && (csr_paddr[CSR_ADDR_W-1] == REG_LOCKOUT)) begin
         lockout_in = csr_pwdata[LOCK_W-1:0];
      end
      csr_prdata = (csr_paddr[CSR_ADDR_W-1] == REG_LOCKOUT) ? CSR_DATA_W'(lockout_ff) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lockout_ff <= LOCKOUT_RESET;
      end else begin
         lockout_ff <= lockout_in;
      end
   end

   // request handshake
   always_comb begin
      req_full = q_stat.full;
      accept   = req_push && !q_stat.full;
   end

   tktl_front u_front (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .req     (req_data),
      .lockout (lockout_ff),
      .job     (job)
   );

   tktl_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (job),
      .pop       (q_pop),
      .pop_data  (q_data),
      .stat      (q_stat)
   );

   tktl_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_data    (q_data),
      .q_stat    (q_stat),
      .q_pop     (q_pop),
      .rsp_pop   (rsp_pop),
      .rsp_empty (rsp_empty),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

>>> hw/rtl/tktl_front.sv
`default_nettype none
module tktl_front
   import tktl_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              accept,
   input  wire req_type           req,
   input  wire logic [LOCK_W-1:0] lockout,
   output job_type                job
);

   logic [LOCK_W-1:0]   cnt_ff [NUM_KEYS];
   logic [LOCK_W-1:0]   cnt_in [NUM_KEYS];
   logic [NUM_KEYS-1:0] toggle;

   // classify: a key toggles when its counter is idle and it is pressed
   always_comb begin
      for (int k = 0; k < NUM_KEYS; k++) begin
         toggle[k] = (cnt_ff[k] == '0) && req.key_bits[KEY_POS[k]];
         cnt_in[k] = cnt_ff[k];
         if (accept && (req.op == OP_SCAN)) begin
            if (toggle[k]) begin
               cnt_in[k] = lockout;
            end else if (cnt_ff[k] != '0) begin
               cnt_in[k] = cnt_ff[k] - LOCK_W'(1);
            end
         end
      end
      job.op      = req.op;
      job.mask    = (req.op == OP_SCAN) ? toggle : '0;
      job.rx_byte = req.rx_byte;
   end

   // per-key lockout counters
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_KEYS; k++) begin
            cnt_ff[k] <= '0;
         end
      end else begin
         for (int k = 0; k < NUM_KEYS; k++) begin
            cnt_ff[k] <= cnt_in[k];
         end
      end
   end

   // a toggling key 0 reloads its counter with the lockout value
   a_reload: assert property (@(posedge clock) disable iff (reset)
      accept && (req.op == OP_SCAN) && toggle[0] |=> cnt_ff[0] == $past(lockout))
      else $error("key counter not reloaded after toggle");

endmodule
`default_nettype wire

>>> hw/rtl/tktl_queue.sv
`default_nettype none
module tktl_queue
   import tktl_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire job_type push_data,
   input  wire logic    pop,
   output job_type      pop_data,
   output q_stat_type   stat
);

   job_type              slot_ff [JOB_DEPTH];
   logic [JOB_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [JOB_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [JOB_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 do_push, do_pop;

   // pointer and fill bookkeeping
   always_comb begin
      stat.full  = (cnt_ff == JOB_CNT_W'(JOB_DEPTH));
      stat.empty = (cnt_ff == '0);
      do_push    = push && !stat.full;
      do_pop     = pop && !stat.empty;
      pop_data   = slot_ff[rd_ptr_ff];
      wr_ptr_in  = wr_ptr_ff;
      rd_ptr_in  = rd_ptr_ff;
      cnt_in     = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == JOB_PTR_W'(JOB_DEPTH - 1)) ? '0 : wr_ptr_ff + JOB_PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == JOB_PTR_W'(JOB_DEPTH - 1)) ? '0 : rd_ptr_ff + JOB_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + JOB_CNT_W'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - JOB_CNT_W'(1);
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= JOB_CNT_W'(JOB_DEPTH))
      else $error("job queue overfilled");

   a_fill_step: assert property (@(posedge clock) disable iff (reset)
      do_push && !do_pop |=> cnt_ff == $past(cnt_ff) + JOB_CNT_W'(1))
      else $error("job queue count lost a push");

endmodule
`default_nettype wire

>>> hw/rtl/tktl_back.sv
`default_nettype none
module tktl_back
   import tktl_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire job_type    q_data,
   input  wire q_stat_type q_stat,
   output logic            q_pop,
   input  wire logic       rsp_pop,
   output logic            rsp_empty,
   output rsp_type         rsp_data
);

   logic                job_valid_ff, job_valid_in;
   job_type             job_ff, job_in;
   logic [CTRL_W-1:0]   ctrl_ff, ctrl_in;
   logic                out_valid_ff, out_valid_in;
   rsp_type             out_ff, out_in;

   logic                emit, job_done, load;
   logic [NUM_KEYS-1:0] low_bit, remain;
   logic [CTRL_W-1:0]   ctrl_new;
   logic                send;

   // expand the current job into one result per cycle while the output register is free or popped
   always_comb begin
      emit     = job_valid_ff && (!out_valid_ff || rsp_pop);
      low_bit  = job_ff.mask & (~job_ff.mask + NUM_KEYS'(1));
      remain   = job_ff.mask & ~low_bit;
      ctrl_new = (job_ff.op == OP_RX) ? job_ff.rx_byte : (ctrl_ff ^ CTRL_W'(low_bit));
      send     = (job_ff.op == OP_RX) || (job_ff.mask != '0);
      job_done = emit && ((job_ff.op == OP_RX) || (remain == '0));
      load     = !job_valid_ff || job_done;
      q_pop    = load && !q_stat.empty;

      out_in              = out_ff;
      out_in.control_byte = ctrl_new;
      out_in.led_drive    = ~ctrl_new[DRIVE_W-1:0];
      out_in.gate_drive   = ctrl_new[CTRL_W-1:DRIVE_W];
      out_in.send_valid   = send;
      out_in.send_byte    = send ? ctrl_new : '0;
      out_in.last         = (job_ff.op == OP_RX) || (remain == '0);

      ctrl_in = emit ? ctrl_new : ctrl_ff;

      job_valid_in = load ? !q_stat.empty : job_valid_ff;
      job_in       = job_ff;
      if (q_pop) begin
         job_in = q_data;
      end else if (emit) begin
         job_in.mask = remain;
      end

      if (emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end

      rsp_empty = !out_valid_ff;
      rsp_data  = out_ff;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         job_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         ctrl_ff      <= '0;
      end else begin
         job_valid_ff <= job_valid_in;
         out_valid_ff <= out_valid_in;
         ctrl_ff      <= ctrl_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      job_ff <= job_in;
      if (emit) begin
         out_ff <= out_in;
      end
   end

   a_quiet_byte: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !out_ff.send_valid |-> out_ff.send_byte == '0 && out_ff.last)
      else $error("quiet result carries a send byte or is not last");

   a_led_map: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> out_ff.led_drive == ~out_ff.control_byte[DRIVE_W-1:0])
      else $error("led drive does not follow control byte");

   a_ctrl_track: assert property (@(posedge clock) disable iff (reset)
      $past(emit) |-> ctrl_ff == out_ff.control_byte)
      else $error("control state and emitted byte disagree");

endmodule
`default_nettype wire
